// ===== hw/rtl/dle_cap_pkg.sv =====
// shared types, constants and register map of the dle/etx frame capture block
package dle_cap_pkg;

  localparam int unsigned BufBytes = 128;
  localparam int unsigned CountW   = 16;
  localparam int unsigned IndexW   = 7;
  localparam int unsigned AddrW    = 4;
  localparam int unsigned DataW    = 32;

  localparam logic [7:0] EscapeReset  = 8'h10;
  localparam logic [7:0] EndReset     = 8'h03;
  localparam logic [7:0] CaptureReset = 8'h88;

  localparam logic [CountW-1:0] IdPos      = CountW'(2);
  localparam logic [CountW-1:0] PayloadOff = CountW'(3);

  typedef enum logic [1:0] {
    REG_ESCAPE  = 2'd0,
    REG_END     = 2'd1,
    REG_CAPTURE = 2'd2
  } reg_idx_e;

  typedef enum logic {
    OP_BYTE    = 1'b0,
    OP_OVERRUN = 1'b1
  } op_e;

  typedef struct packed {
    logic [7:0] escape_code;
    logic [7:0] end_code;
    logic [7:0] capture_id;
  } cfg_t;

  typedef struct packed {
    logic              store_valid;
    logic              store_bank;
    logic [IndexW-1:0] store_index;
    logic [7:0]        store_data;
    logic              clear_valid;
    logic              clear_bank_sel;
    logic              frame_done;
    logic [7:0]        frame_id;
    logic              in_frame_now;
  } res_t;

endpackage

// ===== hw/rtl/dle_cap_if.sv =====
// valid/ready channel interfaces for received items and capture results
interface dle_cap_item_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [7:0] rx_byte;

  modport source (output valid, output opcode, output rx_byte, input ready);
  modport sink   (input valid, input opcode, input rx_byte, output ready);
endinterface

interface dle_cap_result_if;
  logic       valid;
  logic       ready;
  logic       store_valid;
  logic       store_bank;
  logic [6:0] store_index;
  logic [7:0] store_data;
  logic       clear_valid;
  logic       clear_bank_sel;
  logic       frame_done;
  logic [7:0] frame_id;
  logic       in_frame_now;

  modport source (
    output valid, output store_valid, output store_bank, output store_index,
    output store_data, output clear_valid, output clear_bank_sel,
    output frame_done, output frame_id, output in_frame_now, input ready
  );
  modport sink (
    input valid, input store_valid, input store_bank, input store_index,
    input store_data, input clear_valid, input clear_bank_sel,
    input frame_done, input frame_id, input in_frame_now, output ready
  );
endinterface

// ===== hw/rtl/dle_cap_cfg.sv =====
// apb configuration registers for escape, end and capture codes
module dle_cap_cfg import dle_cap_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready,
  output cfg_t             cfg_o
);

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign idx    = reg_idx_e'(paddr[AddrW-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        REG_ESCAPE:  cfg_d.escape_code = pwdata[7:0];
        REG_END:     cfg_d.end_code    = pwdata[7:0];
        REG_CAPTURE: cfg_d.capture_id  = pwdata[7:0];
        default:     cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_ESCAPE:  prdata = {(DataW-8)'(0), cfg_q.escape_code};
      REG_END:     prdata = {(DataW-8)'(0), cfg_q.end_code};
      REG_CAPTURE: prdata = {(DataW-8)'(0), cfg_q.capture_id};
      default:     prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.escape_code <= EscapeReset;
      cfg_q.end_code    <= EndReset;
      cfg_q.capture_id  <= CaptureReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// ===== hw/rtl/dle_cap_parser.sv =====
// frame parser state and per-byte decode of stores, clears and frame ends
module dle_cap_parser import dle_cap_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  logic       accept_i,
  input  logic       opcode_i,
  input  logic [7:0] rx_byte_i,
  output res_t       res_o
);

  logic              framing_q, framing_d;
  logic [CountW-1:0] count_q, count_d;
  logic [7:0]        msg_id_q, msg_id_d;
  logic [7:0]        id_use_q, id_use_d;
  logic [7:0]        prev_q, prev_d;
  logic              prev_vld_q, prev_vld_d;
  logic              bank_q, bank_d;

  always_comb begin
    logic [CountW-1:0] cnt_inc;
    logic [CountW-1:0] idx;
    logic [7:0]        mid;
    logic              prev_esc;

    framing_d  = framing_q;
    count_d    = count_q;
    msg_id_d   = msg_id_q;
    id_use_d   = id_use_q;
    prev_d     = prev_q;
    prev_vld_d = prev_vld_q;
    bank_d     = bank_q;
    res_o      = '0;

    cnt_inc  = count_q + CountW'(1);
    idx      = cnt_inc - PayloadOff;
    prev_esc = prev_vld_q && (prev_q == cfg_i.escape_code);
    mid      = (cnt_inc == IdPos) ? rx_byte_i : msg_id_q;

    if (op_e'(opcode_i) == OP_OVERRUN) begin
      if ((id_use_q != 8'd0) && (id_use_q == cfg_i.capture_id)) begin
        res_o.clear_valid    = 1'b1;
        res_o.clear_bank_sel = bank_q;
      end
      id_use_d = 8'd0;
    end else if (framing_q) begin
      if ((id_use_q == cfg_i.capture_id) && prev_esc && (rx_byte_i == cfg_i.escape_code)) begin
        prev_vld_d = 1'b0;
        prev_d     = 8'd0;
      end else begin
        count_d  = cnt_inc;
        msg_id_d = mid;
        id_use_d = mid;
        if ((mid == cfg_i.capture_id) && (cnt_inc > IdPos) && (idx < CountW'(BufBytes))) begin
          res_o.store_valid = 1'b1;
          res_o.store_bank  = bank_q;
          res_o.store_index = idx[IndexW-1:0];
          res_o.store_data  = rx_byte_i;
        end
        if ((rx_byte_i == cfg_i.end_code) && prev_esc) begin
          res_o.frame_done = 1'b1;
          res_o.frame_id   = mid;
          if (mid == cfg_i.capture_id) begin
            bank_d = ~bank_q;
          end
          framing_d = 1'b0;
          count_d   = '0;
          msg_id_d  = 8'd0;
          id_use_d  = 8'd0;
        end
        prev_d     = rx_byte_i;
        prev_vld_d = 1'b1;
      end
    end else begin
      if (rx_byte_i == cfg_i.escape_code) begin
        framing_d = 1'b1;
        count_d   = cnt_inc;
      end else begin
        count_d = '0;
      end
    end

    res_o.in_frame_now = framing_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      framing_q  <= 1'b0;
      count_q    <= '0;
      msg_id_q   <= 8'd0;
      id_use_q   <= 8'd0;
      prev_q     <= 8'd0;
      prev_vld_q <= 1'b0;
      bank_q     <= 1'b0;
    end else if (accept_i) begin
      framing_q  <= framing_d;
      count_q    <= count_d;
      msg_id_q   <= msg_id_d;
      id_use_q   <= id_use_d;
      prev_q     <= prev_d;
      prev_vld_q <= prev_vld_d;
      bank_q     <= bank_d;
    end
  end

endmodule

// ===== hw/rtl/dle_cap_out.sv =====
// result register with flow control toward the result channel
module dle_cap_out import dle_cap_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  res_t res_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output res_t res_o
);

  logic vld_q, vld_d;
  res_t res_q;
  logic take;

  assign in_ready_o  = !vld_q || out_ready_i;
  assign take        = in_valid_i && in_ready_o;
  assign vld_d       = take || (vld_q && !out_ready_i);
  assign out_valid_o = vld_q;
  assign res_o       = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      res_q <= res_i;
    end
  end

endmodule

// ===== hw/rtl/dle_etx_frame_capture.sv =====
// top level of the dle/etx frame capture block
// result register: valid in the cycle after the item transfer, freed in the cycle taken
// throughput: one item per cycle, stalled while a held result waits on result_o.ready
// reset: asynchronous active low, parser idle, bank 0, codes at their defaults
// configuration writes take effect on the next item transfer
module dle_etx_frame_capture import dle_cap_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  dle_cap_item_if.sink       item_i,
  dle_cap_result_if.source   result_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [AddrW-1:0]   paddr,
  input  logic [DataW-1:0]   pwdata,
  output logic [DataW-1:0]   prdata,
  output logic               pready
);

  cfg_t cfg;
  res_t res_comb;
  res_t res_reg;
  logic in_ready;
  logic accept;

  assign item_i.ready = in_ready;
  assign accept       = item_i.valid && in_ready;

  dle_cap_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  dle_cap_parser u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .accept_i  (accept),
    .opcode_i  (item_i.opcode),
    .rx_byte_i (item_i.rx_byte),
    .res_o     (res_comb)
  );

  dle_cap_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (item_i.valid),
    .in_ready_o  (in_ready),
    .res_i       (res_comb),
    .out_valid_o (result_o.valid),
    .out_ready_i (result_o.ready),
    .res_o       (res_reg)
  );

  assign result_o.store_valid    = res_reg.store_valid;
  assign result_o.store_bank     = res_reg.store_bank;
  assign result_o.store_index    = res_reg.store_index;
  assign result_o.store_data     = res_reg.store_data;
  assign result_o.clear_valid    = res_reg.clear_valid;
  assign result_o.clear_bank_sel = res_reg.clear_bank_sel;
  assign result_o.frame_done     = res_reg.frame_done;
  assign result_o.frame_id       = res_reg.frame_id;
  assign result_o.in_frame_now   = res_reg.in_frame_now;

endmodule
